/* sv/rtlp_pkg.sv */
// ----------------------------------------------------------------------------
// rtlp_pkg
// Shared types and constants for the longest-prefix route table.
// ----------------------------------------------------------------------------
package rtlp_pkg;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_IFDOWN = 2'd2,
		FUNC_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_NOROUTE = 2'd3
	} status_t;

	localparam logic [31:0] ALL_ONES    = 32'hffffffff;
	localparam logic [5:0]  HOST_PREFIX = 6'd32;
	localparam logic [31:0] MCAST_MASK  = 32'hffffff00;
	localparam logic [31:0] MCAST_NET   = 32'he0000000;

	function automatic logic [31:0] prefix_mask(input logic [5:0] p);
		logic [31:0] m;
		begin
			if (p == 6'd0) begin
				m = 32'd0;
			end else begin
				m = ALL_ONES << (6'd32 - p);
			end
			return m;
		end
	endfunction

endpackage

/* sv/rtlp_ram.sv */
// ----------------------------------------------------------------------------
// rtlp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rtlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/route_table_longest_prefix_top.sv */
// One entry is read per cycle during a scan, and a /32 hit or a local multicast ends a
// lookup early. Only one operation is handled at a time; the next word is taken in the
// cycle after the result is accepted.
// Reset: arst_n clears the entry count and the control; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// route_table_longest_prefix_top
// Ordered IPv4 route table: add, longest-prefix lookup, interface down and
// remove network, each done as at most one sequential scan over the route RAM.
// ----------------------------------------------------------------------------
module route_table_longest_prefix_top
	import rtlp_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int PORT_BITS   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [31:0]          address,
	input  logic [5:0]           prefix_len,
	input  logic [31:0]          next_hop,
	input  logic [PORT_BITS-1:0] port_index,
	input  logic [31:0]          cost,
	input  logic                 filter_on,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [31:0]          route_dest,
	output logic [31:0]          route_gateway,
	output logic [PORT_BITS-1:0] route_port,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] removed_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 32 + 6 + 32 + PORT_BITS + 32;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_DONE = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_q;       // next read index
	logic [CW-1:0]   chk_q;      // index of entry in RAM data
	logic            chk_v_q;
	logic [CW-1:0]   wr_q;
	logic            stop_q;

	func_t           op_q;
	logic [31:0]     addr_q;
	logic [5:0]      pfx_q;
	logic [31:0]     gw_q;
	logic [PORT_BITS-1:0] port_q;
	logic [31:0]     cost_q;
	logic            filt_q;
	logic [31:0]     net_q;

	logic            dup_q;
	logic            hit_q;
	logic [5:0]      longest_q;
	logic [31:0]     best_q;
	logic [31:0]     rdest_q;
	logic [31:0]     rgw_q;
	logic [PORT_BITS-1:0] rport_q;

	logic [EW-1:0]   ram_rdata;
	logic [EW-1:0]   ram_wdata;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;

	logic [31:0]     e_net;
	logic [5:0]      e_pfx;
	logic [31:0]     e_gw;
	logic [PORT_BITS-1:0] e_port;
	logic [31:0]     e_met;
	logic [31:0]     e_mask;
	logic            e_match;
	logic            e_kill;
	logic [5:0]      sat_pfx;

	assign {e_net, e_pfx, e_gw, e_port, e_met} = ram_rdata;
	assign e_mask = prefix_mask(e_pfx);
	assign sat_pfx = (prefix_len > HOST_PREFIX) ? HOST_PREFIX : prefix_len;

	always_comb begin
		e_match = ((addr_q & e_mask) == (e_net & e_mask)) &&
			(!filt_q || e_port == port_q) && (e_pfx >= longest_q);
		e_kill = (e_port == port_q);
		if (op_q == FUNC_REMOVE) begin
			e_kill = e_kill && e_pfx != HOST_PREFIX && e_net == net_q && e_pfx == pfx_q;
		end
	end

	// write port: compaction move or append
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[AW-1:0];
		ram_wdata = ram_rdata;
		if (state_q == S_SCAN && chk_v_q &&
		    (op_q == FUNC_IFDOWN || op_q == FUNC_REMOVE) && !e_kill) begin
			ram_we = (wr_q != chk_q);
		end else if (state_q == S_DONE && op_q == FUNC_ADD && !dup_q &&
		             count_q != DEPTH_C) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = {addr_q, pfx_q, gw_q, port_q, cost_q};
		end
	end

	rtlp_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
			chk_v_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						chk_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					chk_v_q <= (rd_q < count_q) && !stop_q &&
						!(chk_v_q && op_q == FUNC_LOOKUP && e_match &&
						  e_pfx == HOST_PREFIX &&
						  !(e_pfx == longest_q && e_met > best_q));
					if (!chk_v_q && (rd_q >= count_q || stop_q)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (op_q == FUNC_ADD && !dup_q && count_q != DEPTH_C) begin
						count_q <= count_q + 1'b1;
					end else if (op_q == FUNC_IFDOWN || op_q == FUNC_REMOVE) begin
						count_q <= wr_q;
					end
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= func_t'(func);
				addr_q    <= address;
				pfx_q     <= sat_pfx;
				gw_q      <= next_hop;
				port_q    <= port_index;
				cost_q    <= cost;
				filt_q    <= filter_on;
				net_q     <= address & prefix_mask(sat_pfx);
				rd_q      <= '0;
				wr_q      <= '0;
				dup_q     <= 1'b0;
				hit_q     <= 1'b0;
				longest_q <= '0;
				best_q    <= ALL_ONES;
				rdest_q   <= '0;
				rgw_q     <= '0;
				rport_q   <= '0;
				// local multicast answers without a scan
				stop_q    <= (func_t'(func) == FUNC_LOOKUP) &&
					((address & MCAST_MASK) == MCAST_NET);
			end
			S_SCAN: begin
				if (rd_q < count_q && !stop_q) begin
					rd_q <= rd_q + 1'b1;
				end
				chk_q <= rd_q;
				if (chk_v_q) begin
					case (op_q)
						FUNC_ADD: begin
							if (e_net == addr_q && e_pfx == pfx_q && e_gw == gw_q &&
							    e_port == port_q && e_met == cost_q) begin
								dup_q <= 1'b1;
							end
						end
						FUNC_LOOKUP: begin
							if (e_match) begin
								longest_q <= e_pfx;
								if (!(e_pfx == longest_q && e_met > best_q)) begin
									best_q  <= e_met;
									hit_q   <= 1'b1;
									rdest_q <= e_net;
									rgw_q   <= e_gw;
									rport_q <= e_port;
									if (e_pfx == HOST_PREFIX) begin
										stop_q <= 1'b1;
									end
								end else begin
									// reached only for an equal prefix with a worse metric, so best is kept
									if (e_pfx > longest_q) begin
										best_q <= e_met;
									end
								end
							end
						end
						default: begin
							if (!e_kill) begin
								wr_q <= wr_q + 1'b1;
							end
						end
					endcase
				end
			end
			S_DONE: begin
				route_gateway <= rgw_q;
				case (op_q)
					FUNC_ADD: begin
						removed_count <= '0;
						route_dest    <= rdest_q;
						route_port    <= rport_q;
						if (dup_q) begin
							status <= ST_DUP;
						end else if (count_q == DEPTH_C) begin
							status <= ST_FULL;
						end else begin
							status <= ST_OK;
						end
					end
					FUNC_LOOKUP: begin
						removed_count <= '0;
						if (stop_q && !hit_q) begin
							route_dest <= addr_q;
							route_port <= port_q;
							status     <= ST_OK;
						end else begin
							route_dest <= rdest_q;
							route_port <= rport_q;
							status     <= hit_q ? ST_OK : ST_NOROUTE;
						end
					end
					default: begin
						removed_count <= count_q - wr_q;
						route_dest    <= rdest_q;
						route_port    <= rport_q;
						status        <= ST_OK;
					end
				endcase
			end
			default: ;
		endcase
	end

endmodule

/* sv/rtlp_checker.sv */
// ----------------------------------------------------------------------------
// rtlp_checker
// Port-level checks on the route table handshake and result fields.
// ----------------------------------------------------------------------------
module rtlp_checker
	import rtlp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] route_gateway,
	input logic [31:0] route_dest
);

	// one word in flight: no accept while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOROUTE |-> route_gateway == 32'd0 &&
		route_dest == 32'd0) else $error("miss carries route");

	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not ready after result");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid) else $error("input word withdrawn");

endmodule

bind route_table_longest_prefix_top rtlp_checker u_rtlp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.route_gateway (route_gateway),
	.route_dest    (route_dest)
);
